// ----- design/bitmap_with_circular_find_core_defines.svh -----
// ----------------------------------------------------------------------------
// Bitmap with circular find: assertion macros
// Shared property wrappers used by the RTL of the bitmap core.
// ----------------------------------------------------------------------------
`ifndef BITMAP_WITH_CIRCULAR_FIND_CORE_DEFINES_SVH
`define BITMAP_WITH_CIRCULAR_FIND_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BWCF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BWCF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/bwcf_pkg.sv -----
// ----------------------------------------------------------------------------
// Bitmap with circular find: package
// Sizes, request codes, scan control types and word mask helpers.
// ----------------------------------------------------------------------------
package bwcf_pkg;

    // Store geometry.
    localparam int MAX_BITS  = 1024;
    localparam int WORD_BITS = 32;
    localparam int NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW   = $clog2(NUM_WORDS);
    localparam int OFF_W     = $clog2(WORD_BITS);
    localparam int IDX_W     = 10;
    localparam int CAP_W     = 11;
    localparam int REQ_W     = 3;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [WORD_AW-1:0]   t_waddr;
    typedef logic [OFF_W-1:0]     t_off;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_SET        = 3'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd1;
    localparam logic [REQ_W-1:0] REQ_TEST       = 3'd2;
    localparam logic [REQ_W-1:0] REQ_FIND_SET   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_FIND_CLEAR = 3'd4;
    localparam logic [REQ_W-1:0] REQ_SET_ALL    = 3'd5;

    // Control for one pass of the word scanner.
    typedef struct packed {
        logic  want;       // 1: look for a set bit, 0: for a clear bit
        logic  first;      // first visit of the start word
        logic  last;       // return visit of the start word
        t_off  off;        // bit offset of the start index
        t_word cap_mask;   // bits of this word that lie below capacity
    } t_scan_ctl;

    typedef struct packed {
        logic hit;
        t_off pos;
    } t_scan_res;

    // Bits of word w whose index is below the capacity.
    function automatic t_word cap_mask(input t_waddr w, input logic [CAP_W-1:0] cap);
        logic [CAP_W-OFF_W-1:0] full_words;
        t_off                   rem;
        t_word                  m;
        full_words = cap[CAP_W-1:OFF_W];
        rem        = cap[OFF_W-1:0];
        if ((CAP_W-OFF_W)'(w) < full_words) begin
            m = '1;
        end else if ((CAP_W-OFF_W)'(w) == full_words) begin
            m = (t_word'(1) << rem) - t_word'(1);
        end else begin
            m = '0;
        end
        return m;
    endfunction

    // Position of the lowest set bit of a word.
    function automatic t_off lowest_set(input t_word v);
        t_off p;
        p = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                p = t_off'(i);
            end
        end
        return p;
    endfunction

endpackage

// ----- design/bwcf_scan.sv -----
// ----------------------------------------------------------------------------
// Bitmap with circular find: word scanner
// Masks one store word to the bits a search visits and finds the lowest match.
// ----------------------------------------------------------------------------
module bwcf_scan (
    input  bwcf_pkg::t_word     i_word,
    input  bwcf_pkg::t_scan_ctl i_ctl,
    output bwcf_pkg::t_scan_res o_res
);
    import bwcf_pkg::*;

    t_word below_start;
    t_word range_mask;
    t_word cand;

    // The start word is seen twice: first from the start offset upward,
    // and at the end of the lap only below the start offset.
    always_comb begin
        below_start = (t_word'(1) << i_ctl.off) - t_word'(1);
        if (i_ctl.first) begin
            range_mask = ~below_start;
        end else if (i_ctl.last) begin
            range_mask = below_start;
        end else begin
            range_mask = '1;
        end
    end

    // Match polarity, capacity and order window, then priority pick.
    assign cand      = (i_ctl.want ? i_word : ~i_word) & i_ctl.cap_mask & range_mask;
    assign o_res.hit = |cand;
    assign o_res.pos = lowest_set(cand);

endmodule

// ----- design/bitmap_with_circular_find_core.sv -----
// ----------------------------------------------------------------------------
// Bitmap with circular find: core
// Allocation bitmap with set, clear, test, set-all and circular search.
// ----------------------------------------------------------------------------
// Usage: a request (i_req_type, i_bit_index) is taken when i_valid and
// o_ready are both high; o_ready is high only while the sequencer is idle,
// so one request is worked on at a time. Each request gives one result on
// the output channel (o_valid / i_ready), held in an output register.
// Steps from acceptance to o_valid: set, clear, test and unknown codes
// pass the decode state S_EXEC and the finish state S_FIN; a search
// scans in S_SCAN, at most all 32 words plus the return into the start
// word, then passes S_FIN; set-all passes S_EXEC, the sweep that writes
// all 32 words one per cycle, and S_FIN. The next request can be taken
// in the cycle after the result leaves the sequencer. The word store is
// a single memory with one registered read port, and the scanner examines
// one word per cycle.
// A new request may be taken while the previous result still waits; the
// sequencer then holds its finished result until the output register is
// free, so a stalled receiver stalls the block without loss.
// Reset (synchronous, i_rst_n low) empties the bitmap through per-word valid
// bits at once and sets capacity to 1024. Writing the capacity register also
// clears the map; the user must write only while idle; the block won't check.
// ----------------------------------------------------------------------------
`include "bitmap_with_circular_find_core_defines.svh"

module bitmap_with_circular_find_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wen,
    input  logic [bwcf_pkg::CAP_W-1:0]     i_cfg_wdata,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [bwcf_pkg::REQ_W-1:0]     i_req_type,
    input  logic [bwcf_pkg::IDX_W-1:0]     i_bit_index,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_bit_value,
    output logic                           o_found,
    output logic [bwcf_pkg::IDX_W-1:0]     o_found_index,
    output logic [bwcf_pkg::CAP_W-1:0]     o_set_count,
    output logic                           o_is_empty,
    output logic                           o_is_full
);
    import bwcf_pkg::*;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_FILL = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    // Control registers.
    logic [2:0]           r_state, n_state;
    logic                 r_out_valid, n_out_valid;
    logic [NUM_WORDS-1:0] r_vld, n_vld;
    logic [CAP_W-1:0]     r_count, n_count;
    logic [CAP_W-1:0]     r_cap, n_cap;

    // Request context and result registers.
    logic [REQ_W-1:0]     r_req, n_req;
    logic                 r_in_range, n_in_range;
    t_waddr               r_w0, n_w0;
    t_off                 r_off, n_off;
    t_waddr               r_addr, n_addr;
    logic                 r_first, n_first;
    logic                 r_bval, n_bval;
    logic                 r_found, n_found;
    logic [IDX_W-1:0]     r_fidx, n_fidx;

    // Output register.
    logic                 r_o_bval, n_o_bval;
    logic                 r_o_found, n_o_found;
    logic [IDX_W-1:0]     r_o_fidx, n_o_fidx;
    logic [CAP_W-1:0]     r_o_count, n_o_count;
    logic                 r_o_empty, n_o_empty;
    logic                 r_o_full, n_o_full;

    // Word store.
    t_word                r_mem [NUM_WORDS];
    t_word                r_rd_data;
    logic                 mem_we;
    t_word                mem_wdata;
    t_word                eff_word;

    // Scanner interface.
    t_scan_ctl            scan_ctl;
    t_scan_res            scan_res;

    logic                 req_in_range;
    logic [IDX_W-1:0]     req_start;
    t_waddr               last_w;
    logic [CAP_W-1:0]     cap_m1;
    logic [CAP_W-1:0]     cfg_cap;
    logic                 cur_bit;
    t_word                bit_sel;
    logic                 out_free;

    // A word never written since the last clear reads as zero.
    assign eff_word = r_vld[r_addr] ? r_rd_data : '0;
    assign cur_bit  = eff_word[r_off];
    assign bit_sel  = t_word'(1) << r_off;

    // Last word holding bits in use; the search wraps after it.
    assign cap_m1 = r_cap - CAP_W'(1);
    assign last_w = cap_m1[OFF_W +: WORD_AW];

    // Incoming start point, wrapped to zero when beyond capacity.
    assign req_in_range = {1'b0, i_bit_index} < r_cap;
    assign req_start    = req_in_range ? i_bit_index : '0;

    // Capacity write value, held to the legal range.
    always_comb begin
        if (i_cfg_wdata == '0) begin
            cfg_cap = CAP_W'(1);
        end else if (i_cfg_wdata > CAP_W'(MAX_BITS)) begin
            cfg_cap = CAP_W'(MAX_BITS);
        end else begin
            cfg_cap = i_cfg_wdata;
        end
    end

    // Scanner control for the word now at the read port.
    always_comb begin
        scan_ctl.want     = (r_req == REQ_FIND_SET);
        scan_ctl.first    = r_first;
        scan_ctl.last     = !r_first && (r_addr == r_w0);
        scan_ctl.off      = r_off;
        scan_ctl.cap_mask = cap_mask(r_addr, r_cap);
    end

    bwcf_scan u_scan (
        .i_word (eff_word),
        .i_ctl  (scan_ctl),
        .o_res  (scan_res)
    );

    assign o_ready  = (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_ready;

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_ready;
        n_vld       = r_vld;
        n_count     = r_count;
        n_cap       = r_cap;
        n_req       = r_req;
        n_in_range  = r_in_range;
        n_w0        = r_w0;
        n_off       = r_off;
        n_addr      = r_addr;
        n_first     = r_first;
        n_bval      = r_bval;
        n_found     = r_found;
        n_fidx      = r_fidx;
        n_o_bval    = r_o_bval;
        n_o_found   = r_o_found;
        n_o_fidx    = r_o_fidx;
        n_o_count   = r_o_count;
        n_o_empty   = r_o_empty;
        n_o_full    = r_o_full;
        mem_we      = 1'b0;
        mem_wdata   = eff_word;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_req      = i_req_type;
                    n_in_range = req_in_range;
                    n_w0       = req_start[OFF_W +: WORD_AW];
                    n_off      = req_start[OFF_W-1:0];
                    n_addr     = req_start[OFF_W +: WORD_AW];
                    n_first    = 1'b1;
                    n_bval     = 1'b0;
                    n_found    = 1'b0;
                    n_fidx     = '0;
                    if (i_req_type == REQ_FIND_SET || i_req_type == REQ_FIND_CLEAR) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                n_state = S_FIN;
                if (r_in_range && (r_req == REQ_SET || r_req == REQ_CLEAR ||
                                   r_req == REQ_TEST || r_req == REQ_SET_ALL)) begin
                    n_bval = cur_bit;
                end
                if (r_in_range && r_req == REQ_SET && !cur_bit) begin
                    mem_we    = 1'b1;
                    mem_wdata = eff_word | bit_sel;
                    n_count   = r_count + CAP_W'(1);
                end else if (r_in_range && r_req == REQ_CLEAR && cur_bit) begin
                    mem_we    = 1'b1;
                    mem_wdata = eff_word & ~bit_sel;
                    n_count   = r_count - CAP_W'(1);
                end
                if (r_req == REQ_SET_ALL) begin
                    n_addr  = '0;
                    n_state = S_FILL;
                end
            end
            S_SCAN: begin
                if (r_first) begin
                    n_bval = cur_bit;
                end
                n_first = 1'b0;
                if (scan_res.hit) begin
                    n_found = 1'b1;
                    n_fidx  = {r_addr, scan_res.pos};
                    n_state = S_FIN;
                end else if (scan_ctl.last) begin
                    n_state = S_FIN;
                end else begin
                    n_addr = (r_addr == last_w) ? '0 : r_addr + WORD_AW'(1);
                end
            end
            S_FILL: begin
                // One word per cycle, padding bits stay clear.
                mem_we    = 1'b1;
                mem_wdata = cap_mask(r_addr, r_cap);
                if (r_addr == WORD_AW'(NUM_WORDS - 1)) begin
                    n_count = r_cap;
                    n_state = S_FIN;
                end else begin
                    n_addr = r_addr + WORD_AW'(1);
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_bval    = r_bval;
                    n_o_found   = r_found;
                    n_o_fidx    = r_fidx;
                    n_o_count   = r_count;
                    n_o_empty   = (r_count == '0);
                    n_o_full    = (r_count == r_cap);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (mem_we) begin
            n_vld[r_addr] = 1'b1;
        end

        // Capacity write empties the bitmap.
        if (i_cfg_wen) begin
            n_cap   = cfg_cap;
            n_vld   = '0;
            n_count = '0;
        end
    end

    // Control registers with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_vld       <= '0;
            r_count     <= '0;
            r_cap       <= CAP_W'(MAX_BITS);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_vld       <= n_vld;
            r_count     <= n_count;
            r_cap       <= n_cap;
        end
    end

    // Context and result payload.
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_in_range <= n_in_range;
        r_w0       <= n_w0;
        r_off      <= n_off;
        r_addr     <= n_addr;
        r_first    <= n_first;
        r_bval     <= n_bval;
        r_found    <= n_found;
        r_fidx     <= n_fidx;
        r_o_bval   <= n_o_bval;
        r_o_found  <= n_o_found;
        r_o_fidx   <= n_o_fidx;
        r_o_count  <= n_o_count;
        r_o_empty  <= n_o_empty;
        r_o_full   <= n_o_full;
    end

    // Word store: one write port at the current word, registered read of
    // the word the sequencer moves to next.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_addr] <= mem_wdata;
        end
        r_rd_data <= r_mem[n_addr];
    end

    assign o_valid       = r_out_valid;
    assign o_bit_value   = r_o_bval;
    assign o_found       = r_o_found;
    assign o_found_index = r_o_fidx;
    assign o_set_count   = r_o_count;
    assign o_is_empty    = r_o_empty;
    assign o_is_full     = r_o_full;

    // Checks.
    `BWCF_ASSERT_IMP(a_count_le_cap, i_clk, i_rst_n, 1'b1, r_count <= r_cap,
        "set count exceeds capacity")
    `BWCF_ASSERT_IMP(a_found_in_cap, i_clk, i_rst_n, r_state == S_FIN && r_found,
        {1'b0, r_fidx} < r_cap, "search result beyond capacity")
    `BWCF_ASSERT_NXT(a_accept_leaves_idle, i_clk, i_rst_n, i_valid && o_ready,
        r_state != S_IDLE, "accepted request did not start the sequencer")

endmodule

// ----- test/tb_bitmap_with_circular_find_core.sv -----
// ----------------------------------------------------------------------------
// Bitmap with circular find: testbench
// Drives set, clear, test, set-all and circular search requests through the
// request channel and checks every reply against a bit-level shadow of the
// bitmap. A short directed table covers the edges of the index range, the
// capacity clamps, empty and full maps, and unknown request codes. Random
// phases follow under several capacities, with random idling on both sides,
// a long reply stall and pauses that let the block drain.
// ----------------------------------------------------------------------------
module tb_bitmap_with_circular_find_core;

    timeunit 1ns;
    timeprecision 1ps;

    import bwcf_pkg::*;

    // Codes the block does not define; they must leave the map untouched.
    localparam logic [REQ_W-1:0] REQ_RSVD6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RSVD7 = 3'd7;

    localparam int          NUM_PHASES     = 12;
    localparam int          PHASE_REQUESTS = 100;
    localparam int          HOLD_OFF       = 400;
    localparam int          DRAIN_CYCLES   = 40;
    localparam int          STALL_LIMIT    = 4000;
    localparam int unsigned CAP_PLAN [NUM_PHASES] =
        '{1024, 0, 32, 2047, 31, 64, 1, 33, 1024, 96, 0, 0};

    typedef struct packed {
        logic             bit_value;
        logic             found;
        logic [IDX_W-1:0] found_index;
        logic [CAP_W-1:0] set_count;
        logic             is_empty;
        logic             is_full;
    } t_bitmap_reply;

    typedef struct {
        bit               is_cfg;
        logic [CAP_W-1:0] cfg_value;
        logic [REQ_W-1:0] req;
        logic [IDX_W-1:0] idx;
        bit               typed;
        t_bitmap_reply    reply;
    } t_stim_row;

    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             i_cfg_wen    = 1'b0;
    logic [CAP_W-1:0] i_cfg_wdata  = '0;
    logic             i_valid      = 1'b0;
    logic [REQ_W-1:0] i_req_type   = '0;
    logic [IDX_W-1:0] i_bit_index  = '0;
    logic             i_ready      = 1'b0;
    logic             o_ready;
    logic             o_valid;
    logic             o_bit_value;
    logic             o_found;
    logic [IDX_W-1:0] o_found_index;
    logic [CAP_W-1:0] o_set_count;
    logic             o_is_empty;
    logic             o_is_full;

    // Shadow of the block state.
    logic [MAX_BITS-1:0] shadow_map  = '0;
    int unsigned         shadow_ones = 0;
    int unsigned         shadow_cap  = MAX_BITS;

    t_bitmap_reply bitmap_replies [$];
    t_stim_row     directed_rows [$];
    int unsigned   mismatches     = 0;
    int unsigned   stalled_cycles = 0;
    int unsigned   hold_off_reqs  = 0;
    bit            calm           = 1'b0;

    bitmap_with_circular_find_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_bit_index   (i_bit_index),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_bit_value   (o_bit_value),
        .o_found       (o_found),
        .o_found_index (o_found_index),
        .o_set_count   (o_set_count),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full)
    );

    // Clock with a 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Applies one request to the shadow map and returns the reply it must give.
    function automatic t_bitmap_reply apply_request(input logic [REQ_W-1:0] req,
                                                    input logic [IDX_W-1:0] idx);
        t_bitmap_reply r;
        int unsigned   start;
        int unsigned   k;
        int unsigned   pos;
        logic          want;
        r = '0;
        case (req)
            REQ_SET, REQ_CLEAR, REQ_TEST: begin
                if (idx < shadow_cap) begin
                    r.bit_value = shadow_map[idx];
                    if (req == REQ_SET && !shadow_map[idx]) begin
                        shadow_map[idx] = 1'b1;
                        shadow_ones++;
                    end else if (req == REQ_CLEAR && shadow_map[idx]) begin
                        shadow_map[idx] = 1'b0;
                        shadow_ones--;
                    end
                end
            end
            REQ_FIND_SET, REQ_FIND_CLEAR: begin
                // Circular walk from the start; a start out of range begins at zero.
                want        = (req == REQ_FIND_SET);
                start       = (idx < shadow_cap) ? idx : 0;
                r.bit_value = shadow_map[start];
                for (k = 0; k < shadow_cap && !r.found; k++) begin
                    pos = start + k;
                    if (pos >= shadow_cap) begin
                        pos -= shadow_cap;
                    end
                    if (shadow_map[pos] == want) begin
                        r.found       = 1'b1;
                        r.found_index = IDX_W'(pos);
                    end
                end
            end
            REQ_SET_ALL: begin
                if (idx < shadow_cap) begin
                    r.bit_value = shadow_map[idx];
                end
                shadow_map = '0;
                for (k = 0; k < shadow_cap; k++) begin
                    shadow_map[k] = 1'b1;
                end
                shadow_ones = shadow_cap;
            end
            default: begin
            end
        endcase
        r.set_count = CAP_W'(shadow_ones);
        r.is_empty  = (shadow_ones == 0);
        r.is_full   = (shadow_ones == shadow_cap);
        return r;
    endfunction

    // Directed table builders.
    function automatic void add_row(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] idx);
        t_stim_row row;
        row = '{1'b0, '0, req, idx, 1'b0, '0};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_checked(input logic [REQ_W-1:0] req,
                                        input logic [IDX_W-1:0] idx,
                                        input logic bv, input logic fnd,
                                        input int unsigned fidx, input int unsigned cnt,
                                        input logic emp, input logic ful);
        t_stim_row row;
        row = '{1'b0, '0, req, idx, 1'b1, '{bv, fnd, IDX_W'(fidx), CAP_W'(cnt), emp, ful}};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_cfg(input int unsigned value);
        t_stim_row row;
        row = '{1'b1, CAP_W'(value), '0, '0, 1'b0, '0};
        directed_rows.push_back(row);
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Offers one request, holds it until taken, then records its reply.
    task automatic offer_request(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] idx,
                                 input bit typed, input t_bitmap_reply typed_reply);
        t_bitmap_reply predicted;
        i_valid     <= 1'b1;
        i_req_type  <= req;
        i_bit_index <= idx;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        predicted = apply_request(req, idx);
        bitmap_replies.push_back(typed ? typed_reply : predicted);
    endtask

    task automatic sender_idle();
        while (!calm && $urandom_range(99) < 16) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic wait_for_replies();
        i_valid <= 1'b0;
        while (bitmap_replies.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Capacity write; the map empties, out-of-range values clamp.
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
        shadow_cap  = (value == 0) ? 1 : ((value > MAX_BITS) ? MAX_BITS : value);
        shadow_map  = '0;
        shadow_ones = 0;
    endtask

    // Reply side: random stalls, and one long hold-off when asked for.
    initial begin : reply_sink
        int unsigned seen;
        seen = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_reqs != seen) begin
                seen = hold_off_reqs;
                i_ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge i_clk);
            end
            i_ready <= calm || ($urandom_range(99) >= 16);
        end
    end

    // Reply checker.
    always @(posedge i_clk) begin
        t_bitmap_reply want;
        if (i_rst_n && o_valid && i_ready) begin
            if (bitmap_replies.size() == 0) begin
                $error("reply with no request outstanding");
                mismatches++;
            end else begin
                want = bitmap_replies.pop_front();
                compare_field("bit_value", want.bit_value, o_bit_value);
                compare_field("found", want.found, o_found);
                compare_field("found_index", want.found_index, o_found_index);
                compare_field("set_count", want.set_count, o_set_count);
                compare_field("is_empty", want.is_empty, o_is_empty);
                compare_field("is_full", want.is_full, o_is_full);
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stalled_cycles <= 0;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    initial begin
        wait (stalled_cycles >= STALL_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // Stimulus.
    initial begin
        int unsigned      roll;
        int unsigned      phase;
        int unsigned      n;
        int unsigned      cap_value;
        bit               fill;
        logic [REQ_W-1:0] req;
        logic [IDX_W-1:0] idx;

        // Empty map at full capacity, then the edges of the index range.
        add_checked(REQ_TEST, 0, 0, 0, 0, 0, 1, 0);
        add_checked(REQ_TEST, 1023, 0, 0, 0, 0, 1, 0);
        add_checked(REQ_FIND_SET, 5, 0, 0, 0, 0, 1, 0);
        add_checked(REQ_FIND_CLEAR, 1023, 0, 1, 1023, 0, 1, 0);
        add_checked(REQ_SET, 0, 0, 0, 0, 1, 0, 0);
        add_checked(REQ_SET, 1023, 0, 0, 0, 2, 0, 0);
        add_checked(REQ_SET, 1023, 1, 0, 0, 2, 0, 0);
        add_row(REQ_FIND_SET, 1);
        add_checked(REQ_CLEAR, 0, 1, 0, 0, 1, 0, 0);
        add_checked(REQ_CLEAR, 0, 0, 0, 0, 1, 0, 0);
        add_checked(REQ_RSVD6, 1023, 0, 0, 0, 1, 0, 0);
        add_checked(REQ_RSVD7, 0, 0, 0, 0, 1, 0, 0);
        // Full map: no clear bit to find; a search that wraps all the way round.
        add_checked(REQ_SET_ALL, 512, 0, 0, 0, 1024, 0, 1);
        add_checked(REQ_FIND_CLEAR, 7, 1, 0, 0, 1024, 0, 1);
        add_row(REQ_CLEAR, 700);
        add_row(REQ_FIND_CLEAR, 701);
        // Odd capacity: indices beyond it are ignored, search starts wrap to zero.
        add_cfg(33);
        add_row(REQ_SET, 32);
        add_checked(REQ_SET, 33, 0, 0, 0, 1, 0, 0);
        add_checked(REQ_TEST, 1023, 0, 0, 0, 1, 0, 0);
        add_row(REQ_FIND_SET, 40);
        add_checked(REQ_SET_ALL, 1000, 0, 0, 0, 33, 0, 1);
        // A zero capacity acts as one bit.
        add_cfg(0);
        add_checked(REQ_FIND_SET, 0, 0, 0, 0, 0, 1, 0);
        add_checked(REQ_SET, 0, 0, 0, 0, 1, 0, 1);
        add_checked(REQ_FIND_CLEAR, 0, 1, 0, 0, 1, 0, 1);
        add_checked(REQ_SET_ALL, 1, 0, 0, 0, 1, 0, 1);
        // The largest written value clamps to the full map.
        add_cfg(2047);
        add_checked(REQ_TEST, 1023, 0, 0, 0, 0, 1, 0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].is_cfg) begin
                wait_for_replies();
                write_capacity(directed_rows[r].cfg_value);
            end else begin
                sender_idle();
                offer_request(directed_rows[r].req, directed_rows[r].idx,
                              directed_rows[r].typed, directed_rows[r].reply);
            end
        end

        // Random phases, each under its own capacity.
        fill = 1'b1;
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            wait_for_replies();
            cap_value = (CAP_PLAN[phase] == 0 && phase >= 10) ?
                        $urandom_range(1100, 1) : CAP_PLAN[phase];
            write_capacity(CAP_W'(cap_value));
            calm <= (phase == 3);
            if (phase == 5) begin
                hold_off_reqs <= hold_off_reqs + 1;
            end
            for (n = 0; n < PHASE_REQUESTS; n++) begin
                // Alternate between filling and draining the map.
                if (n % 25 == 0) begin
                    fill = $urandom_range(1);
                end
                if (n == PHASE_REQUESTS / 2 && phase % 3 == 0) begin
                    wait_for_replies();
                end
                roll = $urandom_range(99);
                if (roll < 2) begin
                    req = roll[0] ? REQ_RSVD7 : REQ_RSVD6;
                end else if (roll < 5) begin
                    req = REQ_SET_ALL;
                end else if (roll < 15) begin
                    req = REQ_TEST;
                end else if (roll < 35) begin
                    req = REQ_FIND_SET;
                end else if (roll < 55) begin
                    req = REQ_FIND_CLEAR;
                end else if (roll < (fill ? 90 : 65)) begin
                    req = REQ_SET;
                end else begin
                    req = REQ_CLEAR;
                end
                // Mostly in range, some anywhere, some right at the capacity edge.
                roll = $urandom_range(99);
                if (roll < 85) begin
                    idx = IDX_W'($urandom_range(shadow_cap - 1));
                end else if (roll < 95) begin
                    idx = IDX_W'($urandom_range(MAX_BITS - 1));
                end else if (shadow_cap == MAX_BITS || roll[0]) begin
                    idx = IDX_W'(shadow_cap - 1);
                end else begin
                    idx = IDX_W'(shadow_cap);
                end
                sender_idle();
                offer_request(req, idx, 1'b0, '0);
            end
        end

        wait_for_replies();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && bitmap_replies.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/bwcf_pkg.sv
design/bwcf_scan.sv
design/bitmap_with_circular_find_core.sv
test/tb_bitmap_with_circular_find_core.sv
